### rtl/msmi_pkg.sv
// shared types and constants for the servo motion interpolator
package msmi_pkg;
  localparam int CHANNELS = 15;
  localparam int CH_W = 4;
  localparam logic [19:0] MICROS = 20'd1000000;
  localparam logic [7:0] PEEK_RESET = 8'd5;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    FN_GOTO  = 3'd0,
    FN_MOVE  = 3'd1,
    FN_DWELL = 3'd2,
    FN_ABORT = 3'd3,
    FN_TICK  = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [CH_W-1:0]    ch;
    logic signed [15:0] target;
    logic [15:0]        rate;
    logic [31:0]        wmag;
    logic [15:0]        wunit;
    logic [47:0]        now;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMD, ST_GDIV, ST_MMUL, ST_DMUL, ST_CH_LOAD, ST_CH_EVAL, ST_CH_MUL,
    ST_CH_DIV, ST_CH_FIN, ST_OUT
  } state_t;
endpackage

### rtl/msmi_front.sv
// front end: accepts items, drops ones with no effect, queues the rest
module msmi_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [3:0]           in_channel,
  input  logic signed [15:0]   in_target_angle,
  input  logic [15:0]          in_rate,
  input  logic signed [31:0]   in_wait_count,
  input  logic [15:0]          in_wait_unit,
  input  logic [47:0]          in_now_us,
  output logic                 q_valid,
  output msmi_pkg::cmd_t       q_cmd,
  input  logic                 q_pop
);
  import msmi_pkg::*;
  cmd_t q_r [QDEPTH];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  logic keep;
  cmd_t c;
  always_comb begin
    c.func = in_func;
    c.ch = in_channel;
    c.target = in_target_angle;
    c.rate = in_rate;
    c.wmag = in_wait_count[31] ? 32'(-in_wait_count) : in_wait_count;
    c.wunit = in_wait_unit;
    c.now = in_now_us;
    keep = 1'b0;
    if (in_func == FN_TICK) keep = 1'b1;
    else if (in_func <= FN_ABORT && in_channel != '0 && 32'(in_channel) <= CHANNELS)
      keep = !(in_func <= FN_MOVE && in_rate == '0);
  end
  assign in_ready = cnt_r != 2'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_cmd = q_r[rd_r];
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && keep) q_r[wr_r] <= c;
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (in_valid && in_ready && keep) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready && keep) - 2'(q_pop);
    end
  end
endmodule

### rtl/msmi_div.sv
// restoring divider, one quotient bit per cycle, 66-bit dividend by 64-bit divisor
module msmi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [65:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [65:0] quotient
);
  logic [64:0] rem_r;
  logic [65:0] q_r;
  logic [63:0] d_r;
  logic [6:0] n_r;
  logic [64:0] sh;
  always_comb sh = {rem_r[63:0], q_r[65]};
  assign busy = n_r != '0;
  assign quotient = q_r;
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0; q_r <= dividend; d_r <= divisor;
    end else if (busy) begin
      if (sh >= {1'b0, d_r}) begin
        rem_r <= sh - {1'b0, d_r}; q_r <= {q_r[64:0], 1'b1};
      end else begin
        rem_r <= sh; q_r <= {q_r[64:0], 1'b0};
      end
    end
    if (!rst_n) n_r <= '0;
    else if (start) n_r <= 7'd66;
    else if (busy) n_r <= n_r - 7'd1;
  end
endmodule

### rtl/msmi_back.sv
// back end: applies commands to channel state and walks channels on a tick
module msmi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           peek_period,
  input  logic                 q_valid,
  input  msmi_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_channel,
  output logic signed [16:0]   out_angle,
  output logic                 out_angle_valid,
  output logic                 out_want_next,
  output logic                 out_want_peek,
  output logic                 out_last
);
  import msmi_pkg::*;
  logic done_r [CHANNELS];
  logic dwell_r [CHANNELS];
  logic signed [16:0] pres_r [CHANNELS];
  logic signed [16:0] sang_r [CHANNELS];
  logic signed [17:0] dist_r [CHANNELS];
  logic [47:0] stime_r [CHANNELS];
  logic [63:0] dur_r [CHANNELS];
  logic [7:0] pcnt_r, pcnt_nxt;
  state_t st_r, st_nxt;
  cmd_t cmd_r;
  logic [3:0] ci_r;
  logic [3:0] idx;
  logic [17:0] m_r;
  logic [47:0] el_r;
  logic [65:0] prod_r;
  logic signed [16:0] ang_r;
  logic av_r, wn_r, wp_r, fin_done_r;
  logic dstart, dbusy;
  logic [65:0] dquo, ddiv;
  logic [63:0] ddsr;
  logic signed [17:0] ndist;
  logic signed [18:0] adiff;
  assign idx = ci_r;
  assign adiff = 19'(cmd_r.target) - 19'(pres_r[idx]);
  assign ndist = adiff[17:0];
  msmi_div u_div (.clk, .rst_n, .start(dstart), .dividend(ddiv), .divisor(ddsr),
                  .busy(dbusy), .quotient(dquo));
  always_comb begin
    st_nxt = st_r; q_pop = 1'b0; dstart = 1'b0;
    ddiv = prod_r; ddsr = dur_r[idx]; pcnt_nxt = pcnt_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        st_nxt = ST_CMD;
      end
      ST_CMD: begin
        if (cmd_r.func == FN_TICK) begin
          pcnt_nxt = (pcnt_r == '0 ? peek_period : pcnt_r) - 8'd1;
          st_nxt = ST_CH_LOAD;
        end else if (cmd_r.func == FN_GOTO) begin
          dstart = 1'b1; ddiv = 66'(MICROS); ddsr = 64'(cmd_r.rate);
          st_nxt = ST_GDIV;
        end else if (cmd_r.func == FN_MOVE) begin
          st_nxt = ST_MMUL;
        end else if (cmd_r.func == FN_DWELL) begin
          st_nxt = ST_DMUL;
        end else st_nxt = ST_IDLE;
      end
      ST_GDIV: if (!dbusy) st_nxt = ST_DMUL;
      ST_MMUL: st_nxt = ST_DMUL;
      ST_DMUL: st_nxt = ST_IDLE;
      ST_CH_LOAD: st_nxt = ST_CH_EVAL;
      ST_CH_EVAL: begin
        if (!done_r[idx] && !dwell_r[idx] && {16'd0, el_r} < dur_r[idx])
          st_nxt = ST_CH_MUL;
        else st_nxt = ST_CH_FIN;
      end
      ST_CH_MUL: begin
        dstart = 1'b1; st_nxt = ST_CH_DIV;
      end
      ST_CH_DIV: if (!dbusy) st_nxt = ST_CH_FIN;
      ST_CH_FIN: st_nxt = ST_OUT;
      ST_OUT: if (out_ready)
        st_nxt = (32'(ci_r) == CHANNELS - 1) ? ST_IDLE : ST_CH_LOAD;
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign out_valid = st_r == ST_OUT;
  assign out_channel = ci_r;
  assign out_angle = ang_r;
  assign out_angle_valid = av_r;
  assign out_want_next = wn_r;
  assign out_want_peek = wp_r;
  assign out_last = 32'(ci_r) == CHANNELS - 1;
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    if (st_r == ST_IDLE && q_valid) ci_r <= q_cmd.ch - 4'd1;
    if (st_r == ST_CMD && cmd_r.func == FN_TICK) ci_r <= '0;
    if (st_r == ST_OUT && out_ready) ci_r <= ci_r + 4'd1;
    if (st_r == ST_CMD) m_r <= ndist[17] ? 18'(-ndist) : ndist;
    if (st_r == ST_MMUL) prod_r <= 66'(m_r) * 66'(cmd_r.rate);
    if (st_r == ST_DMUL) begin
      stime_r[idx] <= cmd_r.now;
      if (cmd_r.func == FN_DWELL) dur_r[idx] <= 64'(cmd_r.wmag) * 64'(cmd_r.wunit);
      else if (cmd_r.func == FN_MOVE)
        dur_r[idx] <= 64'(prod_r[33:0]) * 64'(MICROS);
      else dur_r[idx] <= 64'(dquo[19:0]) * 64'(m_r);
    end
    if (st_r == ST_CMD && (cmd_r.func == FN_GOTO || cmd_r.func == FN_MOVE)) begin
      sang_r[idx] <= pres_r[idx];
      dist_r[idx] <= ndist;
    end
    if (st_r == ST_CH_LOAD) el_r <= cmd_r.now - stime_r[idx];
    if (st_r == ST_CH_EVAL) begin
      prod_r <= 66'(el_r) * 66'(dist_r[idx][17] ? 18'(-dist_r[idx]) : dist_r[idx]);
      wn_r <= done_r[idx]; wp_r <= !done_r[idx] && pcnt_r == '0;
      if (done_r[idx]) begin
        av_r <= 1'b0; ang_r <= '0; fin_done_r <= 1'b1;
      end else if (dwell_r[idx]) begin
        av_r <= 1'b0; ang_r <= '0; fin_done_r <= {16'd0, el_r} >= dur_r[idx];
      end else if ({16'd0, el_r} >= dur_r[idx]) begin
        av_r <= 1'b1; fin_done_r <= 1'b1;
        ang_r <= 17'(18'(sang_r[idx]) + dist_r[idx]);
      end else begin
        av_r <= 1'b1; ang_r <= '0; fin_done_r <= 1'b0;
      end
    end
    if (st_r == ST_CH_DIV && !dbusy)
      ang_r <= dist_r[idx][17] ? sang_r[idx] - 17'(dquo[17:0])
                               : sang_r[idx] + 17'(dquo[17:0]);
    if (!rst_n) begin
      st_r <= ST_IDLE; pcnt_r <= PEEK_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        done_r[i] <= 1'b1; dwell_r[i] <= 1'b0; pres_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt; pcnt_r <= pcnt_nxt;
      if (st_r == ST_CMD) begin
        if (cmd_r.func == FN_ABORT) done_r[idx] <= 1'b1;
        else if (cmd_r.func != FN_TICK) begin
          done_r[idx] <= 1'b0; dwell_r[idx] <= cmd_r.func == FN_DWELL;
        end
      end
      if (st_r == ST_CH_FIN) begin
        done_r[idx] <= fin_done_r;
        if (av_r) pres_r[idx] <= ang_r;
      end
    end
  end
endmodule

### rtl/multi_servo_motion_interpolator_core.sv
// top level of the multi-servo motion interpolator
// Usage: commands (goto, move, dwell, abort) and ticks arrive as transfers on
// the in_ channel. A command gives no result; a tick gives one result per
// channel on the out_ channel, channel 0 first, out_last on the final one.
// A two-entry queue parts the input from the sequencer, so up to two items
// wait in it while a tick is still being walked.
// A goto command runs the shared bit-serial divider, and a tick runs it once
// for each moving channel still short of its end time, so moving channels take
// longer than idle or dwelling ones.
// Reset (synchronous, rst_n low) makes all channels idle, angles zero and
// the peek period and countdown five. cfg_we writes the peek period.
// When out_ready is low the sequencer holds the result and waits; input
// transfers stop once the queue is full.
module multi_servo_motion_interpolator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_peek_period,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_func,
  input  logic [3:0]          in_channel,
  input  logic signed [15:0]  in_target_angle,
  input  logic [15:0]         in_rate,
  input  logic signed [31:0]  in_wait_count,
  input  logic [15:0]         in_wait_unit,
  input  logic [47:0]         in_now_us,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_channel,
  output logic signed [16:0]  out_angle,
  output logic                out_angle_valid,
  output logic                out_want_next,
  output logic                out_want_peek,
  output logic                out_last
);
  import msmi_pkg::*;
  logic [7:0] period_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;
  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= PEEK_RESET;
    else if (cfg_we) period_r <= cfg_peek_period;
  end
  msmi_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_func, .in_channel,
    .in_target_angle, .in_rate, .in_wait_count, .in_wait_unit, .in_now_us,
    .q_valid, .q_cmd, .q_pop);
  msmi_back u_back (.clk, .rst_n, .peek_period(period_r), .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_ready, .out_channel, .out_angle, .out_angle_valid,
    .out_want_next, .out_want_peek, .out_last);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_want_next && out_angle_valid)) else $error("next with angle");
  a_peek: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_want_next && out_want_peek)) else $error("peek on idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel))
    else $error("result dropped");
endmodule

### tb/tb_multi_servo_motion_interpolator_core.sv
// testbench for the multi-servo motion interpolator: directed and random items checked by a scoreboard
module tb_multi_servo_motion_interpolator_core;
  import msmi_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct {
    logic [2:0]         fn;
    logic [3:0]         ch;
    logic signed [15:0] tgt;
    logic [15:0]        rate;
    logic signed [31:0] wcount;
    logic [15:0]        wunit;
    logic [47:0]        now;
  } servo_cmd_t;

  typedef struct {
    logic [3:0]         ch;
    logic signed [16:0] angle;
    logic               angle_valid;
    logic               want_next;
    logic               want_peek;
    logic               last;
  } servo_result_t;

  class servo_scoreboard;
    logic [7:0]         period, countdown;
    bit                 done[CHANNELS], dwelling[CHANNELS];
    logic signed [16:0] start_ang[CHANNELS], present[CHANNELS];
    logic signed [17:0] dst[CHANNELS];
    logic [47:0]        t0[CHANNELS];
    logic [63:0]        dur[CHANNELS];
    servo_result_t      pending_q[$];
    int                 errors;

    function new();
      period = PEEK_RESET;
      countdown = PEEK_RESET;
      errors = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        done[i] = 1;
        dwelling[i] = 0;
        present[i] = '0;
      end
    endfunction

    function void set_period(logic [7:0] v);
      period = v;
    endfunction

    function void note_input(servo_cmd_t it);
      int                 c, diff;
      logic [17:0]        m;
      logic [31:0]        w;
      logic [47:0]        el;
      logic [65:0]        quo;
      logic [17:0]        q;
      logic signed [19:0] a;
      servo_result_t      r;
      if (it.fn == FN_GOTO || it.fn == FN_MOVE || it.fn == FN_DWELL || it.fn == FN_ABORT) begin
        if (it.ch == 0 || it.ch > CHANNELS) return;
        c = it.ch - 1;
        if (it.fn == FN_GOTO || it.fn == FN_MOVE) begin
          if (it.rate == 0) return;
          diff = int'(it.tgt) - int'(present[c]);
          dst[c] = diff[17:0];
          m = dst[c][17] ? 18'(-dst[c]) : dst[c];
          dwelling[c] = 0;
          start_ang[c] = present[c];
          t0[c] = it.now;
          if (it.fn == FN_GOTO)
            dur[c] = (64'(MICROS) / 64'(it.rate)) * 64'(m);
          else
            dur[c] = 64'(m) * 64'(it.rate) * 64'(MICROS);
          done[c] = 0;
        end else if (it.fn == FN_DWELL) begin
          w = it.wcount[31] ? 32'(-it.wcount) : it.wcount;
          dwelling[c] = 1;
          t0[c] = it.now;
          dur[c] = 64'(w) * 64'(it.wunit);
          done[c] = 0;
        end else begin
          done[c] = 1;
        end
        return;
      end
      if (it.fn != FN_TICK) return;
      if (countdown == 0) countdown = period;
      countdown = countdown - 8'd1;
      for (int i = 0; i < CHANNELS; i++) begin
        r = '{ch: 4'(i), angle: '0, angle_valid: 0, want_next: 0, want_peek: 0,
              last: (i == CHANNELS - 1)};
        if (!done[i]) begin
          el = it.now - t0[i];
          if (dwelling[i]) begin
            if (64'(el) >= dur[i]) done[i] = 1;
          end else begin
            if (64'(el) < dur[i]) begin
              m = dst[i][17] ? 18'(-dst[i]) : dst[i];
              quo = (66'(el) * 66'(m)) / 66'(dur[i]);
              q = quo[17:0];
              a = dst[i][17] ? 20'(start_ang[i]) - $signed({2'b0, q})
                             : 20'(start_ang[i]) + $signed({2'b0, q});
            end else begin
              a = 20'(start_ang[i]) + 20'(dst[i]);
              done[i] = 1;
            end
            present[i] = a[16:0];
            r.angle = a[16:0];
            r.angle_valid = 1;
          end
          if (countdown == 0) r.want_peek = 1;
        end else begin
          r.want_next = 1;
        end
        pending_q.push_back(r);
      end
    endfunction

    function void check_result(servo_result_t got);
      servo_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result on channel %0d", got.ch);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.ch !== exp_r.ch || got.angle !== exp_r.angle ||
          got.angle_valid !== exp_r.angle_valid || got.want_next !== exp_r.want_next ||
          got.want_peek !== exp_r.want_peek || got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp ch %0d ang %0d v %b n %b p %b l %b / got ch %0d ang %0d v %b n %b p %b l %b",
                   exp_r.ch, exp_r.angle, exp_r.angle_valid, exp_r.want_next, exp_r.want_peek,
                   exp_r.last, got.ch, got.angle, got.angle_valid, got.want_next,
                   got.want_peek, got.last);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [7:0]         cfg_peek_period = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         in_func = '0;
  logic [3:0]         in_channel = '0;
  logic signed [15:0] in_target_angle = '0;
  logic [15:0]        in_rate = '0;
  logic signed [31:0] in_wait_count = '0;
  logic [15:0]        in_wait_unit = '0;
  logic [47:0]        in_now_us = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [3:0]         out_channel;
  logic signed [16:0] out_angle;
  logic               out_angle_valid, out_want_next, out_want_peek, out_last;

  servo_scoreboard sb = new();
  int              cycles = 0;
  int              stall_mode = 0;
  logic [47:0]     clock_us = 48'd1000;

  always #1 clk = ~clk;

  multi_servo_motion_interpolator_core u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_peek_period(cfg_peek_period),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_channel(in_channel),
    .in_target_angle(in_target_angle), .in_rate(in_rate), .in_wait_count(in_wait_count),
    .in_wait_unit(in_wait_unit), .in_now_us(in_now_us), .out_valid(out_valid),
    .out_ready(out_ready), .out_channel(out_channel), .out_angle(out_angle),
    .out_angle_valid(out_angle_valid), .out_want_next(out_want_next),
    .out_want_peek(out_want_peek), .out_last(out_last)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: checks each accepted result against the scoreboard and varies its stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_channel, out_angle, out_angle_valid, out_want_next,
                        out_want_peek, out_last});
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 99) < 70);
      2: out_ready <= ($urandom_range(0, 99) < 20);
      default: out_ready <= ((cycles / 8) % 2 == 0);
    endcase
  end

  task automatic push_cmd(servo_cmd_t it);
    in_valid <= 1;
    in_func <= it.fn;
    in_channel <= it.ch;
    in_target_angle <= it.tgt;
    in_rate <= it.rate;
    in_wait_count <= it.wcount;
    in_wait_unit <= it.wunit;
    in_now_us <= it.now;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic pause(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_period(logic [7:0] v);
    cfg_we <= 1;
    cfg_peek_period <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_period(v);
  endtask

  function automatic servo_cmd_t mk(logic [2:0] fn, logic [3:0] ch, logic signed [15:0] tgt,
                                    logic [15:0] rate, logic signed [31:0] wc,
                                    logic [15:0] wu, logic [47:0] now);
    servo_cmd_t it;
    it = '{fn, ch, tgt, rate, wc, wu, now};
    return it;
  endfunction

  function automatic servo_cmd_t rand_item();
    servo_cmd_t it;
    int         k;
    k = $urandom_range(0, 99);
    if (k < 5) clock_us = 48'({$urandom(), $urandom()});
    else if (k < 8) clock_us = clock_us - $urandom_range(0, 5000);
    else if (k < 12) clock_us = clock_us + $urandom();
    else clock_us = clock_us + $urandom_range(0, 3000);
    it.now = clock_us;
    it.ch = 4'($urandom_range(1, CHANNELS));
    it.tgt = 16'($urandom_range(0, 65535));
    it.rate = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(2000, 65535));
    it.wcount = ($urandom_range(0, 3) == 0) ? $urandom() : $signed(32'($urandom_range(0, 20))) *
                ($urandom_range(0, 1) ? -1 : 1);
    it.wunit = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 200));
    k = $urandom_range(0, 99);
    if (k < 38) it.fn = FN_TICK;
    else if (k < 60) it.fn = FN_GOTO;
    else if (k < 70) begin
      it.fn = FN_MOVE;
      it.rate = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'd1;
      it.tgt = it.tgt >>> 8;
    end else if (k < 82) it.fn = FN_DWELL;
    else if (k < 89) it.fn = FN_ABORT;
    else if (k < 93) it.fn = 3'($urandom_range(5, 7));
    else if (k < 96) begin
      it.fn = FN_GOTO;
      it.ch = 0;
    end else begin
      it.fn = $urandom_range(0, 1) ? FN_GOTO : FN_MOVE;
      it.rate = 0;
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    int left;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
        left = $urandom_range(1, 12);
      end
      push_cmd(rand_item());
      left--;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed part
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd0));
    push_cmd(mk(FN_GOTO, 0, 16'sd100, 16'd100, 0, 0, 48'd10));
    push_cmd(mk(FN_GOTO, 4'd1, 16'sh7fff, 16'd0, 0, 0, 48'd10));
    push_cmd(mk(FN_GOTO, 4'd1, 16'sh7fff, 16'hffff, 0, 0, 48'd100));
    push_cmd(mk(FN_GOTO, 4'd15, -16'sd32768, 16'hffff, 0, 0, 48'd100));
    push_cmd(mk(FN_MOVE, 4'd2, -16'sd5, 16'd1, 0, 0, 48'd100));
    push_cmd(mk(FN_GOTO, 4'd3, 16'sd0, 16'd1, 0, 0, 48'd100));
    push_cmd(mk(FN_DWELL, 4'd4, 0, 0, -32'sd2147483648, 16'hffff, 48'd100));
    push_cmd(mk(FN_DWELL, 4'd5, 0, 0, 32'sd3, 16'd10, 48'd100));
    push_cmd(mk(FN_DWELL, 4'd6, 0, 0, 32'sd0, 16'd0, 48'd100));
    push_cmd(mk(3'd5, 4'd7, 0, 0, 0, 0, 48'd100));
    push_cmd(mk(3'd7, 4'd7, 0, 0, 0, 0, 48'd100));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd120));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd500000));
    push_cmd(mk(FN_ABORT, 4'd2, 0, 0, 0, 0, 48'd0));
    push_cmd(mk(FN_ABORT, 4'd0, 0, 0, 0, 0, 48'd0));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'hffff_ffff_ffff));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd50));
    push_cmd(mk(FN_GOTO, 4'd15, 16'sh7fff, 16'hffff, 0, 0, 48'hffff_ffff_fff0));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd1000));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd2000000));
    push_cmd(mk(FN_TICK, 0, 0, 0, 0, 0, 48'd2000001));
    drain();
    write_period(8'd1);
    random_phase(40);
    drain();
    write_period(8'd255);
    random_phase(40);
    drain();
    write_period(8'd0);
    random_phase(20);
    pause(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
    random_phase(20);
    drain();
    write_period(8'($urandom_range(2, 9)));
    random_phase(40);
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
